// ----- sv/tskt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the timestamp-sorted keyed table.
// No dependencies.
package tskt_pkg;

   typedef enum logic [2:0] {
      REQ_ADD     = 3'd0,
      REQ_RM_KEY  = 3'd1,
      REQ_CLEAR   = 3'd2,
      REQ_READ    = 3'd3,
      REQ_RM_POS  = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      RSP_UNCHANGED   = 3'd0,
      RSP_ADDED       = 3'd1,
      RSP_CHANGED     = 3'd2,
      RSP_REMOVED     = 3'd3,
      RSP_READ        = 3'd4,
      RSP_NOT_FOUND   = 3'd5,
      RSP_FULL        = 3'd6,
      RSP_CLEAR_EMPTY = 3'd7
   } rsp_code_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [15:0]        key_id;
      logic signed [63:0] stamp;
      logic [3:0]         position;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         code;
      logic [15:0]        out_key;
      logic signed [63:0] out_stamp;
      logic [4:0]         fill_count;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      DP_NONE, DP_CAPTURE, DP_LOOKUP, DP_DELETE, DP_INSERT, DP_POP
   } dp_op_type;

   // where the result key/stamp come from
   typedef enum logic [2:0] {
      SRC_REQ, SRC_REQ_KEY, SRC_SEL, SRC_HEAD, SRC_ZERO
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOKUP, ST_DECIDE, ST_DELETE, ST_INSERT, ST_EMIT, ST_CLEAR
   } state_type;

   typedef struct packed {
      dp_op_type    op;
      logic         emit;
      rsp_code_type code;
      src_type      src;
      logic         zero_fill;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_code;
      logic       found;
      logic       same_stamp;
      logic       full;
      logic       empty;
      logic       one_left;
      logic       out_free;
   } status_type;

endpackage

// ----- sv/tskt_dp.sv -----
`timescale 1ns / 1ps
// Datapath: slot row with parallel compare-and-shift, lookup and result register.
// Depends on tskt_pkg.
module tskt_dp #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tskt_pkg::req_item_type req_data,
   input  tskt_pkg::cmd_type      cmd,
   output tskt_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tskt_pkg::rsp_type      rsp_data
);
   import tskt_pkg::*;

   localparam int SK_W  = (KEY_BITS < 16) ? KEY_BITS : 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [SK_W-1:0]    key_ff   [DEPTH];
   logic [SK_W-1:0]    key_in   [DEPTH];
   logic signed [63:0] stamp_ff [DEPTH];
   logic signed [63:0] stamp_in [DEPTH];
   logic [CNT_W-1:0]   total_ff, total_in;
   req_item_type       req_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [SK_W-1:0]    sel_key_ff;
   logic signed [63:0] sel_stamp_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [SK_W-1:0]    req_key;
   logic [DEPTH-1:0]   sel;
   logic [IDX_W-1:0]   sel_idx;
   logic [SK_W-1:0]    sel_key;
   logic signed [63:0] sel_stamp;
   logic [DEPTH-1:0]   after;
   logic [IDX_W-1:0]   del_idx;
   logic               out_free;
   logic [15:0]        o_key;
   logic signed [63:0] o_stamp;

   assign req_key  = req_ff.key_id[SK_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign del_idx  = (cmd.op == DP_POP) ? '0 : idx_ff;

   // keys are unique and positions distinct, so sel is at most one-hot
   always_comb begin
      sel       = '0;
      sel_idx   = '0;
      sel_key   = '0;
      sel_stamp = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CNT_W'(i) < total_ff) begin
            if (req_ff.req_type == REQ_ADD || req_ff.req_type == REQ_RM_KEY)
               sel[i] = (key_ff[i] == req_key);
            else
               sel[i] = (32'(req_ff.position) == 32'(i));
         end
         if (sel[i]) begin
            sel_idx   = sel_idx | IDX_W'(i);
            sel_key   = sel_key | key_ff[i];
            sel_stamp = sel_stamp | stamp_ff[i];
         end
      end
   end

   // slots that stay ahead of the new entry (not older than it)
   always_comb begin
      for (int i = 0; i < DEPTH; i++)
         after[i] = (CNT_W'(i) < total_ff) && !(stamp_ff[i] < req_ff.stamp);
   end

   always_comb begin
      key_in   = key_ff;
      stamp_in = stamp_ff;
      total_in = total_ff;
      unique case (cmd.op)
         DP_DELETE, DP_POP: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (IDX_W'(i) >= del_idx) begin
                  key_in[i]   = key_ff[i+1];
                  stamp_in[i] = stamp_ff[i+1];
               end
            end
            total_in = total_ff - CNT_W'(1);
         end
         DP_INSERT: begin
            if (!after[0]) begin
               key_in[0]   = req_key;
               stamp_in[0] = req_ff.stamp;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (!after[i]) begin
                  if (after[i-1]) begin
                     key_in[i]   = req_key;
                     stamp_in[i] = req_ff.stamp;
                  end else begin
                     key_in[i]   = key_ff[i-1];
                     stamp_in[i] = stamp_ff[i-1];
                  end
               end
            end
            total_in = total_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      stamp_ff <= stamp_in;
      if (cmd.op == DP_CAPTURE) req_ff <= req_data;
      if (cmd.op == DP_LOOKUP) begin
         found_ff     <= |sel;
         idx_ff       <= sel_idx;
         sel_key_ff   <= sel_key;
         sel_stamp_ff <= sel_stamp;
      end
      if (reset) total_ff <= '0;
      else       total_ff <= total_in;
   end

   always_comb begin
      unique case (cmd.src)
         SRC_REQ: begin
            o_key = 16'(req_key); o_stamp = req_ff.stamp;
         end
         SRC_REQ_KEY: begin
            o_key = 16'(req_key); o_stamp = '0;
         end
         SRC_SEL: begin
            o_key = 16'(sel_key_ff); o_stamp = sel_stamp_ff;
         end
         SRC_HEAD: begin
            o_key = 16'(key_ff[0]); o_stamp = stamp_ff[0];
         end
         default: begin
            o_key = '0; o_stamp = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_ff.code       <= cmd.code;
         rsp_ff.out_key    <= o_key;
         rsp_ff.out_stamp  <= o_stamp;
         rsp_ff.fill_count <= cmd.zero_fill ? 5'd0 : 5'(total_ff);
         rsp_ff.last       <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.req_code   = req_ff.req_type;
   assign status.found      = found_ff;
   assign status.same_stamp = (sel_stamp_ff == req_ff.stamp);
   assign status.full       = (total_ff == CNT_W'(DEPTH));
   assign status.empty      = (total_ff == '0);
   assign status.one_left   = (total_ff == CNT_W'(1));
   assign status.out_free   = out_free;

`ifndef SYNTH
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_INSERT |-> total_ff < CNT_W'(DEPTH))
      else $error("insert into full table");
   a_delete_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_DELETE || cmd.op == DP_POP) |-> total_ff != '0)
      else $error("delete from empty table");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result overwritten");
   a_reset_clear: assert property (@(posedge clock) reset |=> total_ff == '0)
      else $error("table not cleared by reset");
`endif
endmodule

// ----- sv/tskt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences lookup, delete, insert and result steps.
// Depends on tskt_pkg.
module tskt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_code,
   output logic                 req_ready,
   input  tskt_pkg::status_type status,
   output tskt_pkg::cmd_type    cmd
);
   import tskt_pkg::*;

   state_type    state_ff, state_in;
   rsp_code_type code_ff, code_in;
   src_type      src_ff, src_in;
   logic         ins_ff, ins_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      code_ff <= code_in;
      src_ff  <= src_in;
      ins_ff  <= ins_in;
   end

   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      src_in        = src_ff;
      ins_in        = ins_ff;
      req_ready     = 1'b0;
      cmd.op        = DP_NONE;
      cmd.emit      = 1'b0;
      cmd.code      = code_ff;
      cmd.src       = src_ff;
      cmd.zero_fill = 1'b0;
      cmd.last      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_CAPTURE;
               priority if (req_code == REQ_CLEAR) state_in = ST_CLEAR;
               else if (req_code == REQ_ADD || req_code == REQ_RM_KEY ||
                        req_code == REQ_READ || req_code == REQ_RM_POS)
                  state_in = ST_LOOKUP;
               else state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            cmd.op   = DP_LOOKUP;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            ins_in = 1'b0;
            priority if (status.req_code == REQ_ADD) begin
               priority if (status.found && status.same_stamp) begin
                  cmd.code = RSP_UNCHANGED; cmd.src = SRC_REQ;
                  cmd.emit = status.out_free;
               end else if (status.found) begin
                  code_in = RSP_CHANGED; src_in = SRC_REQ; ins_in = 1'b1;
                  state_in = ST_DELETE;
               end else if (status.full) begin
                  cmd.code = RSP_FULL; cmd.src = SRC_REQ;
                  cmd.emit = status.out_free;
               end else begin
                  code_in = RSP_ADDED; src_in = SRC_REQ;
                  state_in = ST_INSERT;
               end
            end else if (status.req_code == REQ_RM_KEY) begin
               if (!status.found) begin
                  cmd.code = RSP_NOT_FOUND; cmd.src = SRC_REQ_KEY;
                  cmd.emit = status.out_free;
               end else begin
                  code_in = RSP_REMOVED; src_in = SRC_SEL; state_in = ST_DELETE;
               end
            end else if (status.req_code == REQ_READ) begin
               cmd.code = status.found ? RSP_READ : RSP_NOT_FOUND;
               cmd.src  = status.found ? SRC_SEL : SRC_ZERO;
               cmd.emit = status.out_free;
            end else begin
               if (!status.found) begin
                  cmd.code = RSP_NOT_FOUND; cmd.src = SRC_ZERO;
                  cmd.emit = status.out_free;
               end else begin
                  code_in = RSP_REMOVED; src_in = SRC_SEL; state_in = ST_DELETE;
               end
            end
            if (cmd.emit) state_in = ST_IDLE;
         end
         ST_DELETE: begin
            cmd.op   = DP_DELETE;
            state_in = ins_ff ? ST_INSERT : ST_EMIT;
         end
         ST_INSERT: begin
            cmd.op   = DP_INSERT;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.zero_fill = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.empty) begin
                  cmd.code = RSP_CLEAR_EMPTY; cmd.src = SRC_ZERO;
                  state_in = ST_IDLE;
               end else begin
                  cmd.op   = DP_POP;
                  cmd.code = RSP_REMOVED; cmd.src = SRC_HEAD;
                  cmd.last = status.one_left;
                  if (status.one_left) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_pop_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_POP |-> state_ff == ST_CLEAR && cmd.emit)
      else $error("pop without a result");
   a_emit_back: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> state_ff == ST_IDLE)
      else $error("final result did not end the request");
`endif
endmodule

// ----- sv/timestamp_sorted_keyed_table_top.sv -----
`timescale 1ns / 1ps
// Clear gives one result per cycle while the result register is free.
// One request at a time: ready is high only in idle, set by the controller
// sequence lookup / delete / insert / result, one slot-row step a cycle; a
// result step waits until the result register is free.
// A result register lets the next request enter while the last result waits.
// Reset (synchronous, active high) empties the table and drops any pending result.
module timestamp_sorted_keyed_table_top #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tskt_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tskt_pkg::rsp_type      rsp_data
);
   import tskt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: sequences each request
   tskt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_code  (req_data.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: slot row, lookup, result register
   tskt_dp #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

// ----- test/timestamp_sorted_keyed_table_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for timestamp_sorted_keyed_table_top: random and directed requests,
// a behavioral table predictor and a result scoreboard. Depends on tskt_pkg and the DUT.
module timestamp_sorted_keyed_table_top_tb;
   import tskt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int IDLE_LIMIT  = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;

   timestamp_sorted_keyed_table_top #(.DEPTH(TABLE_DEPTH), .KEY_BITS(16)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Predictor copy of the table, newest first.
   logic [15:0]        tbl_key   [TABLE_DEPTH];
   logic signed [63:0] tbl_stamp [TABLE_DEPTH];
   int                 tbl_fill;

   req_item_type pending_reqs [$];
   rsp_type      expected_rsps [$];
   int           mismatch_count;
   int           idle_cycles;
   bit           stim_done;
   int           send_gap;
   int           recv_gap;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch: %s", what);
   endtask

   function automatic void push_rsp(input rsp_code_type c, input logic [15:0] k,
                                    input logic signed [63:0] s, input int fill,
                                    input logic lst);
      rsp_type r;
      r.code = c; r.out_key = k; r.out_stamp = s;
      r.fill_count = fill[4:0]; r.last = lst;
      expected_rsps.push_back(r);
   endfunction

   function automatic int find_slot(input logic [15:0] k);
      for (int i = 0; i < tbl_fill; i++)
         if (tbl_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void drop_slot(input int p);
      for (int i = p; i + 1 < tbl_fill; i++) begin
         tbl_key[i]   = tbl_key[i+1];
         tbl_stamp[i] = tbl_stamp[i+1];
      end
      tbl_fill--;
   endfunction

   // Equal stamps go after existing entries (arrival order kept).
   function automatic void place_sorted(input logic [15:0] k, input logic signed [63:0] s);
      int p;
      p = 0;
      while (p < tbl_fill && !(tbl_stamp[p] < s)) p++;
      for (int i = tbl_fill; i > p; i--) begin
         tbl_key[i]   = tbl_key[i-1];
         tbl_stamp[i] = tbl_stamp[i-1];
      end
      tbl_key[p] = k; tbl_stamp[p] = s;
      tbl_fill++;
   endfunction

   function automatic void predict_table(input req_item_type rq);
      int idx;
      logic signed [63:0] s;
      logic [15:0] k;
      case (rq.req_type)
         REQ_ADD: begin
            idx = find_slot(rq.key_id);
            if (idx >= 0 && tbl_stamp[idx] == rq.stamp) begin
               push_rsp(RSP_UNCHANGED, rq.key_id, rq.stamp, tbl_fill, 1'b1);
            end else if (idx >= 0) begin
               drop_slot(idx);
               place_sorted(rq.key_id, rq.stamp);
               push_rsp(RSP_CHANGED, rq.key_id, rq.stamp, tbl_fill, 1'b1);
            end else if (tbl_fill >= TABLE_DEPTH) begin
               push_rsp(RSP_FULL, rq.key_id, rq.stamp, tbl_fill, 1'b1);
            end else begin
               place_sorted(rq.key_id, rq.stamp);
               push_rsp(RSP_ADDED, rq.key_id, rq.stamp, tbl_fill, 1'b1);
            end
         end
         REQ_RM_KEY: begin
            idx = find_slot(rq.key_id);
            if (idx < 0) begin
               push_rsp(RSP_NOT_FOUND, rq.key_id, '0, tbl_fill, 1'b1);
            end else begin
               s = tbl_stamp[idx];
               drop_slot(idx);
               push_rsp(RSP_REMOVED, rq.key_id, s, tbl_fill, 1'b1);
            end
         end
         REQ_CLEAR: begin
            if (tbl_fill == 0) begin
               push_rsp(RSP_CLEAR_EMPTY, '0, '0, 0, 1'b1);
            end else begin
               for (int i = 0; i < tbl_fill; i++)
                  push_rsp(RSP_REMOVED, tbl_key[i], tbl_stamp[i], 0, i + 1 == tbl_fill);
               tbl_fill = 0;
            end
         end
         REQ_READ, REQ_RM_POS: begin
            if (int'(rq.position) >= tbl_fill) begin
               push_rsp(RSP_NOT_FOUND, '0, '0, tbl_fill, 1'b1);
            end else begin
               k = tbl_key[rq.position];
               s = tbl_stamp[rq.position];
               if (rq.req_type == REQ_READ) begin
                  push_rsp(RSP_READ, k, s, tbl_fill, 1'b1);
               end else begin
                  drop_slot(int'(rq.position));
                  push_rsp(RSP_REMOVED, k, s, tbl_fill, 1'b1);
               end
            end
         end
         default: ;   // unused request codes: no result
      endcase
   endfunction

   function automatic req_item_type make_req(input logic [2:0] t, input logic [15:0] k,
                                             input logic signed [63:0] s,
                                             input logic [3:0] p);
      req_item_type r;
      r.req_type = t; r.key_id = k; r.stamp = s; r.position = p;
      return r;
   endfunction

   // Stamps from a small pool so ties and updates happen often.
   function automatic logic signed [63:0] rand_stamp();
      case ($urandom_range(0, 4))
         0: return 64'sh8000_0000_0000_0000;
         1: return 64'sh7FFF_FFFF_FFFF_FFFF;
         2: return {$urandom, $urandom};
         default: return $signed(64'($urandom_range(0, 7))) - 64'sd3;
      endcase
   endfunction

   function automatic logic [15:0] rand_key();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 23));
   endfunction

   // Stimulus: directed corners, then a random mix.
   initial begin
      int r;
      pending_reqs.push_back(make_req(REQ_CLEAR, 16'hFFFF, '1, 4'hF));
      pending_reqs.push_back(make_req(REQ_READ, '0, '0, '0));
      pending_reqs.push_back(make_req(REQ_RM_POS, '0, '0, 4'hF));
      pending_reqs.push_back(make_req(REQ_RM_KEY, 16'hFFFF, '0, '0));
      pending_reqs.push_back(make_req(REQ_ADD, 16'hFFFF, 64'sh7FFF_FFFF_FFFF_FFFF, '0));
      pending_reqs.push_back(make_req(REQ_ADD, 16'h0000, 64'sh8000_0000_0000_0000, '0));
      pending_reqs.push_back(make_req(REQ_ADD, 16'h0001, 64'sh7FFF_FFFF_FFFF_FFFF, 4'hF));
      pending_reqs.push_back(make_req(REQ_ADD, 16'h0001, 64'sh7FFF_FFFF_FFFF_FFFF, '0));
      pending_reqs.push_back(make_req(REQ_ADD, 16'h0001, -64'sd1, '0));
      pending_reqs.push_back(make_req(3'd5, 16'h1234, '0, '0));
      pending_reqs.push_back(make_req(3'd7, 16'h1234, '0, '0));
      pending_reqs.push_back(make_req(REQ_READ, '0, '0, 4'd1));
      pending_reqs.push_back(make_req(REQ_READ, '0, '0, 4'd3));
      pending_reqs.push_back(make_req(REQ_RM_POS, '0, '0, 4'd1));
      pending_reqs.push_back(make_req(REQ_RM_KEY, 16'hFFFF, '0, '0));
      // fill to full, then two more adds to hit the full case
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(make_req(REQ_ADD, 16'(16'h0100 + i), 64'sd5, '0));
      pending_reqs.push_back(make_req(REQ_READ, '0, '0, 4'hF));
      pending_reqs.push_back(make_req(REQ_CLEAR, '0, '0, '0));
      for (int i = 0; i < 150; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            pending_reqs.push_back(make_req(REQ_ADD, rand_key(), rand_stamp(), 4'($urandom)));
         else if (r < 62)
            pending_reqs.push_back(make_req(REQ_RM_KEY, rand_key(), {$urandom, $urandom},
                                            4'($urandom)));
         else if (r < 67)
            pending_reqs.push_back(make_req(REQ_CLEAR, 16'($urandom), {$urandom, $urandom},
                                            4'($urandom)));
         else if (r < 82)
            pending_reqs.push_back(make_req(REQ_READ, 16'($urandom), {$urandom, $urandom},
                                            4'($urandom)));
         else if (r < 97)
            pending_reqs.push_back(make_req(REQ_RM_POS, 16'($urandom), {$urandom, $urandom},
                                            4'($urandom)));
         else
            pending_reqs.push_back(make_req(3'($urandom_range(5, 7)), 16'($urandom), '0, '0));
      end
      stim_done = 1'b1;
   end

   // Driver: feeds queued requests with random gaps; after request 60 it holds off
   // until the scoreboard drains.
   int sent_count;
   always @(posedge clock) begin
      int next_sent;
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         send_gap   <= 0;
         sent_count <= 0;
      end else begin
         next_sent = sent_count;
         if (req_valid && req_ready) begin
            predict_table(req_data);
            next_sent = sent_count + 1;
         end
         sent_count <= next_sent;
         if (req_valid && !req_ready) begin
            // hold payload until accepted
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (next_sent == 60 && expected_rsps.size() != 0) begin
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
            send_gap  <= gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random backpressure and result checking.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected result %p", rsp_data));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.code != want.code)
                  report_mismatch($sformatf("code %0d want %0d", rsp_data.code, want.code));
               if (rsp_data.out_key != want.out_key)
                  report_mismatch($sformatf("key %h want %h", rsp_data.out_key, want.out_key));
               if (rsp_data.out_stamp != want.out_stamp)
                  report_mismatch($sformatf("stamp %h want %h", rsp_data.out_stamp,
                                            want.out_stamp));
               if (rsp_data.fill_count != want.fill_count)
                  report_mismatch($sformatf("fill %0d want %0d", rsp_data.fill_count,
                                            want.fill_count));
               if (rsp_data.last != want.last)
                  report_mismatch($sformatf("last %b want %b", rsp_data.last, want.last));
            end
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap  <= gap_len();
         end
      end
   end

   // Watchdog: cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tskt_pkg.sv
sv/tskt_dp.sv
sv/tskt_ctrl.sv
sv/timestamp_sorted_keyed_table_top.sv
test/timestamp_sorted_keyed_table_top_tb.sv
